// ----- rtl/ugbl_pkg.sv -----
// Shared types and constants of the uniform grid bilinear lookup.
// No dependencies; used by ugbl_axis, ugbl_blend and the top.
`default_nettype none
package ugbl_pkg;
	localparam int FRAC_BITS = 16;
	localparam logic [16:0] FRAC_ONE = 17'h10000;
	localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

	typedef enum logic [2:0] {
		CFG_TEMP_MIN    = 3'd0,
		CFG_TEMP_STEP   = 3'd1,
		CFG_TEMP_POINTS = 3'd2,
		CFG_PRES_MIN    = 3'd3,
		CFG_PRES_STEP   = 3'd4,
		CFG_PRES_POINTS = 3'd5,
		CFG_TABLE_READY = 3'd6
	} cfg_idx_t;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// word control travelling beside the axis pipelines
	typedef struct packed {
		logic        vld;
		logic        lookup;
		logic        nrdy;
		logic        wr;
		logic [7:0]  row;
		logic [7:0]  col;
		logic [31:0] entry;
	} side_t;

	// word control travelling beside the table read and blend
	typedef struct packed {
		logic vld;
		logic lookup;
		logic nrdy;
		logic tc;
		logic pc;
	} tail_t;
endpackage
`default_nettype wire

// ----- rtl/ugbl_ram.sv -----
// Generic single write, single read RAM with registered read data.
// No dependencies.
`default_nettype none
module ugbl_ram #(
	parameter int DW    = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DW-1:0]            wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DW-1:0]            rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) mem[waddr] <= wdata;
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ----- rtl/ugbl_delay.sv -----
// Stall-aware delay line for control and sideband words.
// No dependencies; widths set by the instantiating module.
`default_nettype none
module ugbl_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);
	logic [W-1:0] tap_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) tap_q[i] <= '0;
		end else if (en) begin
			tap_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[DEPTH-1];
endmodule
`default_nettype wire

// ----- rtl/ugbl_axis.sv -----
// One grid axis: clamp, pipelined restoring divide, cell index and Q1.16 fraction.
// Uses ugbl_pkg. All stages advance only while en is high.
`default_nettype none
module ugbl_axis #(
	parameter int W       = 24,
	parameter int PTS_MAX = 256,
	parameter int QB      = 24
) (
	input  wire logic                       clk,
	input  wire logic                       en,
	input  wire logic [W-1:0]               x,
	input  wire logic [W-1:0]               lo,
	input  wire logic [W-1:0]               step,
	input  wire logic [8:0]                 points,
	output logic      [$clog2(PTS_MAX)-1:0] idx,
	output logic      [16:0]                frac,
	output logic                            clamped
);
	localparam int PB = $clog2(PTS_MAX);
	localparam int NW = $clog2(PTS_MAX + 1);
	localparam int HW = W + NW;
	localparam int IB = QB - ugbl_pkg::FRAC_BITS;

	logic [NW-1:0] n, nm1;
	logic [W-1:0]  step_e;

	always_comb begin
		if (points < 9'd2) n = NW'(2);
		else if (32'(points) > PTS_MAX) n = NW'(PTS_MAX);
		else n = NW'(points);
		nm1 = n - NW'(1);
		step_e = (step == '0) ? W'(1) : step;
	end

	logic [W-1:0]  x_s1;
	logic [HW-1:0] hi_s1;
	logic [W-1:0]  d_s2;
	logic          cl_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= x;
			hi_s1 <= HW'(lo) + HW'(nm1) * HW'(step_e);
			if (x_s1 <= lo) begin
				d_s2  <= '0;
				cl_s2 <= 1'b1;
			end else if (HW'(x_s1) >= hi_s1) begin
				d_s2  <= W'(hi_s1 - HW'(lo));
				cl_s2 <= 1'b1;
			end else begin
				d_s2  <= x_s1 - lo;
				cl_s2 <= 1'b0;
			end
		end
	end

	// quotient of (d << 16) / step, one bit per stage
	logic [W-1:0]  rem_dv [QB+1];
	logic [QB-1:0] quo_dv [QB+1];
	logic [W-1:0]  d_dv   [QB+1];
	logic          cl_dv  [QB+1];

	assign rem_dv[0] = d_s2 >> IB;
	assign quo_dv[0] = '0;
	assign d_dv[0]   = d_s2;
	assign cl_dv[0]  = cl_s2;

	for (genvar i = 0; i < QB; i++) begin : g_div
		localparam int B = QB - 1 - i;
		logic         dbit;
		logic [W:0]   t;
		logic         ge;
		if (B >= ugbl_pkg::FRAC_BITS) begin : g_bit
			assign dbit = d_dv[i][B-ugbl_pkg::FRAC_BITS];
		end else begin : g_zero
			assign dbit = 1'b0;
		end
		assign t  = {rem_dv[i], dbit};
		assign ge = t >= {1'b0, step_e};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_dv[i+1] <= ge ? W'(t - {1'b0, step_e}) : t[W-1:0];
				quo_dv[i+1] <= {quo_dv[i][QB-2:0], ge};
				d_dv[i+1]   <= d_dv[i];
				cl_dv[i+1]  <= cl_dv[i];
			end
		end
	end

	logic [IB-1:0] qi;
	assign qi = quo_dv[QB][QB-1:ugbl_pkg::FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			clamped <= cl_dv[QB];
			// landing exactly on the upper end uses the last cell at full fraction
			if (32'(qi) >= 32'(nm1)) begin
				idx  <= PB'(n - NW'(2));
				frac <= ugbl_pkg::FRAC_ONE;
			end else begin
				idx  <= PB'(qi);
				frac <= {1'b0, quo_dv[QB][ugbl_pkg::FRAC_BITS-1:0]};
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/ugbl_blend.sv -----
// Bilinear blend of four corner entries with round to nearest and saturation.
// Uses ugbl_pkg. The result is combinational off the last of the enabled blend stages.
`default_nettype none
module ugbl_blend #(
	parameter int VALUE_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] f00,
	input  wire logic [31:0] f10,
	input  wire logic [31:0] f01,
	input  wire logic [31:0] f11,
	input  wire logic [16:0] u,
	input  wire logic [16:0] v,
	output logic      [31:0] res
);
	localparam int VB = (VALUE_BITS < 32) ? VALUE_BITS : 32;
	localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (VB - 1)) - 34'sd1;
	localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

	logic [48:0] p00_s1, p10_s1, p01_s1, p11_s1;
	logic [16:0] v_s1, v_s2;
	logic [48:0] a0_s2, a1_s2;
	logic [48:0] m0l_s3, m1l_s3;
	logic [33:0] m0h_s3, m1h_s3;
	logic [65:0] acc_s4;
	logic [16:0] ui;

	assign ui = ugbl_pkg::FRAC_ONE - u;

	always_ff @(posedge clk) begin
		if (en) begin
			// corners offset to unsigned by flipping the sign bit
			p00_s1 <= 49'(ui) * 49'(f00 ^ ugbl_pkg::SIGN_FLIP);
			p10_s1 <= 49'(u)  * 49'(f10 ^ ugbl_pkg::SIGN_FLIP);
			p01_s1 <= 49'(ui) * 49'(f01 ^ ugbl_pkg::SIGN_FLIP);
			p11_s1 <= 49'(u)  * 49'(f11 ^ ugbl_pkg::SIGN_FLIP);
			v_s1   <= v;
			a0_s2  <= p00_s1 + p10_s1;
			a1_s2  <= p01_s1 + p11_s1;
			v_s2   <= v_s1;
			m0l_s3 <= 49'(ugbl_pkg::FRAC_ONE - v_s2) * 49'(a0_s2[31:0]);
			m0h_s3 <= 34'(ugbl_pkg::FRAC_ONE - v_s2) * 34'(a0_s2[48:32]);
			m1l_s3 <= 49'(v_s2) * 49'(a1_s2[31:0]);
			m1h_s3 <= 34'(v_s2) * 34'(a1_s2[48:32]);
			acc_s4 <= 66'(m0l_s3) + 66'(m1l_s3) + ((66'(m0h_s3) + 66'(m1h_s3)) << 32)
				+ 66'(ugbl_pkg::SIGN_FLIP);
		end
	end

	logic signed [33:0] r;
	always_comb begin
		r = $signed({1'b0, acc_s4[64:32]}) - $signed({2'b00, ugbl_pkg::SIGN_FLIP});
		if (r > SAT_HI) r = SAT_HI;
		else if (r < SAT_LO) r = SAT_LO;
		res = r[31:0];
	end
endmodule
`default_nettype wire

// ----- rtl/uniform_grid_bilinear_lookup_top.sv -----
// Uniform grid bilinear lookup: two axis pipelines, four table replicas, blend.
// Uses ugbl_pkg, ugbl_axis, ugbl_delay, ugbl_ram and ugbl_blend.
//
// Input channel (in_valid / in_stall): command 0 writes entry_value at
// (row_index, column_index); command 1 looks up at (temperature, pressure).
// Every input word yields exactly one output word on out_valid / out_stall,
// in order: the blended value with clamp flags, zero for a write, or
// not_ready set when table_ready is 0.
// Throughput is one word per cycle while the output is not stalled. QB is the
// divider quotient width (16 fraction bits plus the cell index bits of the
// larger axis); the dividers resolve one quotient bit per stage. Each corner
// comes from its own table replica, so the four reads happen in the same
// cycle; writes go to all replicas in order with lookups. The whole pipeline
// holds while out_valid is high and out_stall is high; the stall shows back
// on in_stall, nothing is dropped or repeated. The config port (cfg_valid /
// cfg_ready, always ready) must be written only while the block is empty;
// the block does not enforce this. Reset restores register defaults and
// empties the pipeline; table contents are undefined until written.
`default_nettype none
module uniform_grid_bilinear_lookup_top #(
	parameter int TEMP_POINTS_MAX = 256,
	parameter int PRES_POINTS_MAX = 256,
	parameter int VALUE_BITS      = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [29:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic [7:0]         row_index,
	input  wire logic [7:0]         column_index,
	input  wire logic signed [31:0] entry_value,
	input  wire logic [23:0]        temperature,
	input  wire logic [29:0]        pressure,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      value,
	output logic                    temp_clamped,
	output logic                    pres_clamped,
	output logic                    not_ready
);
	localparam int TPB   = $clog2(TEMP_POINTS_MAX);
	localparam int PPB   = $clog2(PRES_POINTS_MAX);
	localparam int QB    = ((TPB > PPB) ? TPB : PPB) + ugbl_pkg::FRAC_BITS;
	localparam int DEPTH = TEMP_POINTS_MAX * PRES_POINTS_MAX;
	localparam int AW    = $clog2(DEPTH);

	// configuration registers
	logic [23:0] temp_min_q, temp_step_q;
	logic [8:0]  temp_points_q, pres_points_q;
	logic [29:0] pres_min_q, pres_step_q;
	logic        table_ready_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_min_q    <= '0;
			temp_step_q   <= 24'd512;
			temp_points_q <= 9'd2;
			pres_min_q    <= '0;
			pres_step_q   <= 30'd50000;
			pres_points_q <= 9'd2;
			table_ready_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ugbl_pkg::CFG_TEMP_MIN:    temp_min_q    <= cfg_data[23:0];
				ugbl_pkg::CFG_TEMP_STEP:   temp_step_q   <= cfg_data[23:0];
				ugbl_pkg::CFG_TEMP_POINTS: temp_points_q <= cfg_data[8:0];
				ugbl_pkg::CFG_PRES_MIN:    pres_min_q    <= cfg_data;
				ugbl_pkg::CFG_PRES_STEP:   pres_step_q   <= cfg_data;
				ugbl_pkg::CFG_PRES_POINTS: pres_points_q <= cfg_data[8:0];
				ugbl_pkg::CFG_TABLE_READY: table_ready_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// axis pipelines
	logic [TPB-1:0] it;
	logic [PPB-1:0] ip;
	logic [16:0]    u, v;
	logic           tc, pc;

	ugbl_axis #(.W(24), .PTS_MAX(TEMP_POINTS_MAX), .QB(QB)) u_temp (
		.clk(clk), .en(en), .x(temperature), .lo(temp_min_q), .step(temp_step_q),
		.points(temp_points_q), .idx(it), .frac(u), .clamped(tc)
	);

	ugbl_axis #(.W(30), .PTS_MAX(PRES_POINTS_MAX), .QB(QB)) u_pres (
		.clk(clk), .en(en), .x(pressure), .lo(pres_min_q), .step(pres_step_q),
		.points(pres_points_q), .idx(ip), .frac(v), .clamped(pc)
	);

	ugbl_pkg::side_t side_in, side_out;

	always_comb begin
		side_in.vld    = in_valid;
		side_in.lookup = (command == ugbl_pkg::CMD_LOOKUP) && table_ready_q;
		side_in.nrdy   = (command == ugbl_pkg::CMD_LOOKUP) && !table_ready_q;
		side_in.wr     = in_valid && (command == ugbl_pkg::CMD_WRITE)
			&& (32'(row_index) < PRES_POINTS_MAX) && (32'(column_index) < TEMP_POINTS_MAX);
		side_in.row    = row_index;
		side_in.col    = column_index;
		side_in.entry  = entry_value;
	end

	ugbl_delay #(.W($bits(ugbl_pkg::side_t)), .DEPTH(QB + 3)) u_side (
		.clk(clk), .arst_n(arst_n), .en(en), .d(side_in), .q(side_out)
	);

	// address stage
	logic [AW-1:0]   a00_s1, a10_s1, a01_s1, a11_s1, wa_s1;
	logic [31:0]     wd_s1;
	logic            we_s1;
	logic [16:0]     u_s1, v_s1, u_s2, v_s2;
	ugbl_pkg::tail_t tail_s1, tail_out;
	logic [AW-1:0]   base;

	assign base = AW'(ip) * AW'(TEMP_POINTS_MAX) + AW'(it);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			we_s1   <= 1'b0;
			tail_s1 <= '0;
		end else if (en) begin
			we_s1          <= side_out.wr;
			tail_s1.vld    <= side_out.vld;
			tail_s1.lookup <= side_out.lookup;
			tail_s1.nrdy   <= side_out.nrdy;
			tail_s1.tc     <= tc;
			tail_s1.pc     <= pc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a00_s1 <= base;
			a10_s1 <= base + AW'(1);
			a01_s1 <= base + AW'(TEMP_POINTS_MAX);
			a11_s1 <= base + AW'(TEMP_POINTS_MAX) + AW'(1);
			wa_s1  <= AW'(side_out.row) * AW'(TEMP_POINTS_MAX) + AW'(side_out.col);
			wd_s1  <= side_out.entry;
			u_s1   <= u;
			v_s1   <= v;
			u_s2   <= u_s1;
			v_s2   <= v_s1;
		end
	end

	// one replica per corner, all written together
	logic [31:0] f00, f10, f01, f11;

	ugbl_ram #(.DW(32), .DEPTH(DEPTH)) u_ram00 (
		.clk(clk), .en(en), .we(we_s1), .waddr(wa_s1), .wdata(wd_s1),
		.raddr(a00_s1), .rdata(f00)
	);
	ugbl_ram #(.DW(32), .DEPTH(DEPTH)) u_ram10 (
		.clk(clk), .en(en), .we(we_s1), .waddr(wa_s1), .wdata(wd_s1),
		.raddr(a10_s1), .rdata(f10)
	);
	ugbl_ram #(.DW(32), .DEPTH(DEPTH)) u_ram01 (
		.clk(clk), .en(en), .we(we_s1), .waddr(wa_s1), .wdata(wd_s1),
		.raddr(a01_s1), .rdata(f01)
	);
	ugbl_ram #(.DW(32), .DEPTH(DEPTH)) u_ram11 (
		.clk(clk), .en(en), .we(we_s1), .waddr(wa_s1), .wdata(wd_s1),
		.raddr(a11_s1), .rdata(f11)
	);

	// RAM read plus four blend stages
	ugbl_delay #(.W($bits(ugbl_pkg::tail_t)), .DEPTH(5)) u_tail (
		.clk(clk), .arst_n(arst_n), .en(en), .d(tail_s1), .q(tail_out)
	);

	logic [31:0] res;

	ugbl_blend #(.VALUE_BITS(VALUE_BITS)) u_blend (
		.clk(clk), .en(en), .f00(f00), .f10(f10), .f01(f01), .f11(f11),
		.u(u_s2), .v(v_s2), .res(res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= tail_out.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			value        <= tail_out.lookup ? $signed(res) : 32'sd0;
			temp_clamped <= tail_out.lookup && tail_out.tc;
			pres_clamped <= tail_out.lookup && tail_out.pc;
			not_ready    <= tail_out.nrdy;
		end
	end
endmodule
`default_nettype wire

// ----- verif/uniform_grid_bilinear_lookup_top_tb.sv -----
// Testbench for uniform_grid_bilinear_lookup_top: table writes and bilinear lookups
// are checked against a local predictor. Depends on ugbl_pkg and the RTL top only.
`timescale 1ns / 100ps
module uniform_grid_bilinear_lookup_top_tb;

	localparam int GRID_COLS = 256;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic signed [31:0] value;
		logic               tc;
		logic               pc;
		logic               nr;
	} lookup_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [29:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic               command;
	logic [7:0]         row_index;
	logic [7:0]         column_index;
	logic signed [31:0] entry_value;
	logic [23:0]        temperature;
	logic [29:0]        pressure;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] value;
	logic               temp_clamped;
	logic               pres_clamped;
	logic               not_ready;

	// predictor state
	logic [31:0]    grid_store [GRID_COLS*GRID_COLS];
	bit             grid_written [GRID_COLS*GRID_COLS];
	logic [23:0]    t_min, t_step;
	logic [8:0]     t_pts, p_pts;
	logic [29:0]    p_min, p_step;
	logic           tbl_ready;
	lookup_result_t pending_results[$];

	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;

	uniform_grid_bilinear_lookup_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("[uniform_grid_bilinear_lookup_top] ERROR");
		$finish;
	end

	// receiver: random stall, or a long counted hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		lookup_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word value=%0d tc=%b pc=%b nr=%b",
					$time, value, temp_clamped, pres_clamped, not_ready);
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (value !== exp_r.value) begin
					$display("%0t: value exp %0d got %0d", $time, exp_r.value, value);
					errors++;
				end
				if (temp_clamped !== exp_r.tc) begin
					$display("%0t: temp_clamped exp %b got %b", $time, exp_r.tc, temp_clamped);
					errors++;
				end
				if (pres_clamped !== exp_r.pc) begin
					$display("%0t: pres_clamped exp %b got %b", $time, exp_r.pc, pres_clamped);
					errors++;
				end
				if (not_ready !== exp_r.nr) begin
					$display("%0t: not_ready exp %b got %b", $time, exp_r.nr, not_ready);
					errors++;
				end
			end
		end
	end

	function automatic longint unsigned clip_points(input logic [8:0] n);
		if (n < 2) return 2;
		if (n > GRID_COLS) return GRID_COLS;
		return 64'(n);
	endfunction

	// clamp to the axis, give back the Q1.16 fraction, cell index and clamp flag
	function automatic longint unsigned axis_locate(input longint unsigned x,
			input longint unsigned lo, input longint unsigned step_in,
			input longint unsigned n, output longint unsigned cell_idx, output bit clamped);
		longint unsigned stp, hi, d, idx, frac;
		stp = (step_in == 0) ? 1 : step_in;
		hi = lo + (n - 1) * stp;
		clamped = 0;
		if (x <= lo) begin
			x = lo;
			clamped = 1;
		end else if (x >= hi) begin
			x = hi;
			clamped = 1;
		end
		d = x - lo;
		idx = d / stp;
		if (idx >= n - 1) idx = n - 2;
		frac = ((d - idx * stp) << 16) / stp;
		if (frac > 65536) frac = 65536;
		cell_idx = idx;
		return frac;
	endfunction

	function automatic lookup_result_t bilinear_value(input logic cmd, input logic [7:0] row,
			input logic [7:0] col, input logic [31:0] ent, input logic [23:0] tq,
			input logic [29:0] pq);
		lookup_result_t r;
		longint unsigned u, v, it, ip, base, f00, f10, f01, f11, acc;
		bit tc, pc;
		r = '{value: 0, tc: 0, pc: 0, nr: 0};
		if (cmd == ugbl_pkg::CMD_WRITE) begin
			grid_store[row * GRID_COLS + col] = ent;
			grid_written[row * GRID_COLS + col] = 1;
			return r;
		end
		if (!tbl_ready) begin
			r.nr = 1;
			return r;
		end
		u = axis_locate(64'(tq), 64'(t_min), 64'(t_step), clip_points(t_pts), it, tc);
		v = axis_locate(64'(pq), 64'(p_min), 64'(p_step), clip_points(p_pts), ip, pc);
		base = ip * GRID_COLS + it;
		f00 = 64'(grid_store[base] ^ ugbl_pkg::SIGN_FLIP);
		f10 = 64'(grid_store[base + 1] ^ ugbl_pkg::SIGN_FLIP);
		f01 = 64'(grid_store[base + GRID_COLS] ^ ugbl_pkg::SIGN_FLIP);
		f11 = 64'(grid_store[base + GRID_COLS + 1] ^ ugbl_pkg::SIGN_FLIP);
		acc = (65536 - u) * (65536 - v) * f00 + u * (65536 - v) * f10
			+ (65536 - u) * v * f01 + u * v * f11;
		acc = (acc + 64'h8000_0000) >> 32;
		r.value = acc[31:0] ^ ugbl_pkg::SIGN_FLIP;
		r.tc = tc;
		r.pc = pc;
		return r;
	endfunction

	task automatic send_word(input logic cmd, input logic [7:0] row, input logic [7:0] col,
			input logic [31:0] ent, input logic [23:0] tq, input logic [29:0] pq);
		command <= cmd;
		row_index <= row;
		column_index <= col;
		entry_value <= ent;
		temperature <= tq;
		pressure <= pq;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(bilinear_value(cmd, row, col, ent, tq, pq));
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// a lookup, preceded while the table is ready by writes of any corner not yet in the table
	task automatic send_lookup(input logic [23:0] tq, input logic [29:0] pq);
		longint unsigned it, ip, idx;
		longint unsigned frac;
		bit clp;
		if (tbl_ready) begin
			frac = axis_locate(64'(tq), 64'(t_min), 64'(t_step), clip_points(t_pts), it, clp);
			frac = axis_locate(64'(pq), 64'(p_min), 64'(p_step), clip_points(p_pts), ip, clp);
			for (int dr = 0; dr < 2; dr++)
				for (int dc = 0; dc < 2; dc++) begin
					idx = (ip + dr) * GRID_COLS + it + dc;
					if (!grid_written[idx])
						send_word(ugbl_pkg::CMD_WRITE, 8'(ip + dr), 8'(it + dc), $urandom,
							24'($urandom), 30'($urandom));
				end
		end
		send_word(ugbl_pkg::CMD_LOOKUP, 8'($urandom), 8'($urandom), $urandom, tq, pq);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input ugbl_pkg::cfg_idx_t idx, input logic [29:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			ugbl_pkg::CFG_TEMP_MIN:    t_min = data[23:0];
			ugbl_pkg::CFG_TEMP_STEP:   t_step = data[23:0];
			ugbl_pkg::CFG_TEMP_POINTS: t_pts = data[8:0];
			ugbl_pkg::CFG_PRES_MIN:    p_min = data;
			ugbl_pkg::CFG_PRES_STEP:   p_step = data;
			ugbl_pkg::CFG_PRES_POINTS: p_pts = data[8:0];
			ugbl_pkg::CFG_TABLE_READY: tbl_ready = data[0];
			default: ;
		endcase
	endtask

	task automatic set_grid(input logic [23:0] tmin, input logic [23:0] tstep,
			input logic [8:0] tn, input logic [29:0] pmin, input logic [29:0] pstep,
			input logic [8:0] pn, input logic rdy);
		drain();
		write_reg(ugbl_pkg::CFG_TEMP_MIN, 30'(tmin));
		write_reg(ugbl_pkg::CFG_TEMP_STEP, 30'(tstep));
		write_reg(ugbl_pkg::CFG_TEMP_POINTS, 30'(tn));
		write_reg(ugbl_pkg::CFG_PRES_MIN, pmin);
		write_reg(ugbl_pkg::CFG_PRES_STEP, pstep);
		write_reg(ugbl_pkg::CFG_PRES_POINTS, 30'(pn));
		write_reg(ugbl_pkg::CFG_TABLE_READY, 30'(rdy));
		cfg_valid <= 1'b0;
	endtask

	// mostly inside the grid, sometimes any code the field allows
	function automatic longint unsigned pick_coord(input longint unsigned lo,
			input longint unsigned step_in, input logic [8:0] n, input longint unsigned fmax);
		longint unsigned span, x;
		span = (clip_points(n) - 1) * ((step_in == 0) ? 1 : step_in);
		if ($urandom_range(99) < 15) return {$urandom, $urandom} & fmax;
		x = lo + ({$urandom, $urandom} % (span + 1));
		return (x > fmax) ? fmax : x;
	endfunction

	task automatic random_lookups(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 10)
				send_word(ugbl_pkg::CMD_WRITE, 8'($urandom), 8'($urandom), $urandom,
					24'($urandom), 30'($urandom));
			else
				send_lookup(24'(pick_coord(64'(t_min), 64'(t_step), t_pts, 24'hFF_FFFF)),
					30'(pick_coord(64'(p_min), 64'(p_step), p_pts, 30'h3FFF_FFFF)));
		end
	endtask

	task automatic test_reset_state();
		send_lookup(24'h00_1234, 30'd12345);
		send_word(ugbl_pkg::CMD_WRITE, 8'd255, 8'd255, 32'h7FFF_FFFF, 24'hFF_FFFF,
			30'h3FFF_FFFF);
		send_lookup(24'hFF_FFFF, 30'h3FFF_FFFF);
	endtask

	task automatic test_directed_grid();
		set_grid(24'd1000, 24'd512, 9'd3, 30'd100000, 30'd50000, 9'd3, 1'b1);
		send_word(ugbl_pkg::CMD_WRITE, 8'd0, 8'd0, 32'h8000_0000, 24'd0, 30'd0);
		send_word(ugbl_pkg::CMD_WRITE, 8'd0, 8'd1, 32'h7FFF_FFFF, 24'd0, 30'd0);
		send_word(ugbl_pkg::CMD_WRITE, 8'd1, 8'd0, 32'h7FFF_FFFF, 24'd0, 30'd0);
		send_word(ugbl_pkg::CMD_WRITE, 8'd1, 8'd1, 32'h8000_0000, 24'd0, 30'd0);
		send_lookup(24'd0, 30'd0);                      // below both ends
		send_lookup(24'hFF_FFFF, 30'h3FFF_FFFF);        // beyond both ends
		send_lookup(24'd1000, 30'd100000);              // exactly on the first point
		send_lookup(24'd1512, 30'd150000);              // interior grid point
		send_lookup(24'd1256, 30'd125000);              // cell centre, ties
		send_lookup(24'd2024, 30'd200000);              // exactly on the last point
		send_lookup(24'd1001, 30'd199999);
		send_word(ugbl_pkg::CMD_WRITE, 8'd200, 8'd17, 32'hFFFF_FFFF, 24'd5, 30'd7);
		set_grid(24'd1000, 24'd512, 9'd3, 30'd100000, 30'd50000, 9'd3, 1'b0);
		send_lookup(24'd1256, 30'd125000);              // table not ready
	endtask

	task automatic test_register_extremes();
		// points below 2 act as 2, zero step acts as 1
		set_grid(24'd0, 24'd0, 9'd0, 30'd0, 30'd0, 9'd1, 1'b1);
		random_lookups(15);
		// points above the maximum saturate, widest steps
		set_grid(24'hFF_FFFF, 24'hFF_FFFF, 9'd511, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 9'd511, 1'b1);
		random_lookups(15);
		set_grid(24'd0, 24'd1, 9'd256, 30'd0, 30'd1, 9'd256, 1'b1);
		random_lookups(25);
	endtask

	task automatic test_random_phase(input int s_pct, input int r_pct);
		logic [8:0] tn, pn;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int k = 0; k < 3; k++) begin
			tn = 9'(($urandom_range(9) == 0) ? $urandom : $urandom_range(2, 8));
			pn = 9'(($urandom_range(9) == 0) ? $urandom : $urandom_range(2, 8));
			set_grid(24'($urandom),
				24'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 4096)),
				tn, 30'($urandom),
				30'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 200000)),
				pn, $urandom_range(15) != 0);
			random_lookups(100);
		end
	endtask

	task automatic test_backpressure();
		set_grid(24'd2000, 24'd300, 9'd6, 30'd1000, 30'd7000, 9'd5, 1'b1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		hold_left = 300;
		random_lookups(80);
		drain();
		random_lookups(20);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = ugbl_pkg::CFG_TEMP_MIN;
		cfg_data = '0;
		in_valid = 1'b0;
		command = ugbl_pkg::CMD_WRITE;
		row_index = '0;
		column_index = '0;
		entry_value = '0;
		temperature = '0;
		pressure = '0;
		out_stall = 1'b0;
		t_min = 24'd0;
		t_step = 24'd512;
		t_pts = 9'd2;
		p_min = 30'd0;
		p_step = 30'd50000;
		p_pts = 9'd2;
		tbl_ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_directed_grid();
		test_register_extremes();
		test_random_phase(36, 79);
		test_random_phase(79, 36);
		test_random_phase(0, 0);
		test_backpressure();
		drain();

		if (errors == 0)
			$display("[uniform_grid_bilinear_lookup_top] OK");
		else
			$display("[uniform_grid_bilinear_lookup_top] ERROR");
		$finish;
	end
endmodule
